// ----- rtl/rdft_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rdft_pkg
// Shared types and codes for the reading duplicate filter table.
// ---------------------------------------------------------------------------
package rdft_pkg;

  // Default number of table entries
  localparam int unsigned DEPTH_DEFAULT = 128;

  // Field widths
  localparam int unsigned METER_W  = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 7;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // One table entry as held in the store
  typedef struct packed {
    logic [METER_W-1:0] meter;
    logic [TIME_W-1:0]  rtime;
  } entry_t;

endpackage : rdft_pkg
`default_nettype wire

// ----- rtl/rdft_store.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rdft_store
// Entry store: one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module rdft_store #(
  parameter int unsigned TABLE_DEPTH = rdft_pkg::DEPTH_DEFAULT,
  parameter int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire                   clk,
  input  wire                   wr_en,
  input  wire [ADDR_W-1:0]      wr_addr,
  input  rdft_pkg::entry_t      wr_data,
  input  wire [ADDR_W-1:0]      rd_addr,
  output rdft_pkg::entry_t      rd_data
);
  import rdft_pkg::*;

  entry_t mem [TABLE_DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle; the read data is registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : rdft_store
`default_nettype wire

// ----- rtl/reading_duplicate_filter_table.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// reading_duplicate_filter_table
// Meter reading filter: flags repeated report times per meter id.
//
// Pulse start with meter_id and report_time while busy is low. The block
// walks the filled table entries one per cycle, lowest slot first, through
// the single read port of the entry store. Busy stays high while the walk
// runs: it stops at the slot that holds the item's meter, or covers every
// filled entry for a new meter or a full table. When the table is empty busy
// stays low and the item is inserted in slot 0 at once. The result appears
// on status and slot for exactly one cycle, marked by done, in the first
// cycle in which busy is low again (the cycle after the accepting edge when
// the table is empty); it cannot be held off, so the receiver must take it
// then. A new item may be started in the same cycle as done.
// Status: 0 new meter inserted, 1 time updated, 2 duplicate, 3 table full
// (slot 0, nothing recorded). Entries are never removed; reset empties the
// table at once.
// ---------------------------------------------------------------------------
module reading_duplicate_filter_table #(
  parameter int unsigned TABLE_DEPTH = rdft_pkg::DEPTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [rdft_pkg::METER_W-1:0]     meter_id,
  input  wire  [rdft_pkg::TIME_W-1:0]      report_time,
  output logic                             done,
  output logic [rdft_pkg::STATUS_W-1:0]    status,
  output logic [rdft_pkg::SLOT_W-1:0]      slot
);
  import rdft_pkg::*;

  localparam int unsigned ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state;
  logic                state_next;
  logic [ADDR_W-1:0]   scan_idx;
  logic [ADDR_W-1:0]   scan_idx_next;
  logic [COUNT_W-1:0]  used_count;
  logic [COUNT_W-1:0]  used_count_next;
  logic [METER_W-1:0]  req_meter;
  logic [TIME_W-1:0]   req_time;

  logic                done_next;
  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   slot_next;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  entry_t              wr_data;
  logic [ADDR_W-1:0]   rd_addr;
  entry_t              rd_data;

  logic                accept;
  logic [COUNT_W-1:0]  idx_plus_one;
  logic [ADDR_W+SLOT_W-1:0] idx_wide;
  logic [COUNT_W+SLOT_W-1:0] count_wide;

  assign accept       = start && (state == S_IDLE);
  assign busy         = (state != S_IDLE);
  assign idx_plus_one = COUNT_W'(scan_idx) + COUNT_W'(1);
  assign idx_wide     = {{SLOT_W{1'b0}}, scan_idx};
  assign count_wide   = {{SLOT_W{1'b0}}, used_count};

  rdft_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Walk the filled entries, compare, then write back, insert or just report
  always_comb begin
    state_next      = state;
    scan_idx_next   = scan_idx;
    used_count_next = used_count;
    done_next       = 1'b0;
    status_next     = ST_INSERTED;
    slot_next       = '0;
    wr_en           = 1'b0;
    wr_addr         = scan_idx;
    wr_data         = '{meter: req_meter, rtime: req_time};
    rd_addr         = '0;

    case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          wr_data = '{meter: meter_id, rtime: report_time};
          if (used_count == '0) begin
            // Empty table: insert in slot 0 straight away
            wr_en           = 1'b1;
            wr_addr         = '0;
            used_count_next = COUNT_W'(1);
            done_next       = 1'b1;
            status_next     = ST_INSERTED;
            slot_next       = '0;
          end else begin
            scan_idx_next = '0;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = ADDR_W'(idx_plus_one);
        if (rd_data.meter == req_meter) begin
          // Hit: flag duplicate or refresh the stored time
          done_next  = 1'b1;
          slot_next  = idx_wide[SLOT_W-1:0];
          state_next = S_IDLE;
          if (rd_data.rtime == req_time) begin
            status_next = ST_DUPLICATE;
          end else begin
            status_next = ST_UPDATED;
            wr_en       = 1'b1;
            wr_addr     = scan_idx;
          end
        end else if (idx_plus_one < used_count) begin
          // Advance to the next filled entry
          scan_idx_next = ADDR_W'(idx_plus_one);
        end else begin
          // Miss: insert at the next free slot unless the table is full
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (used_count < FULL_COUNT) begin
            wr_en           = 1'b1;
            wr_addr         = ADDR_W'(used_count);
            used_count_next = used_count + COUNT_W'(1);
            status_next     = ST_INSERTED;
            slot_next       = count_wide[SLOT_W-1:0];
          end else begin
            status_next = ST_FULL;
            slot_next   = '0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      done       <= done_next;
    end
  end

  // Hold the item and the result payload
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    status   <= status_next;
    slot     <= slot_next;
    if (accept) begin
      req_meter <= meter_id;
      req_time  <= report_time;
    end
  end

endmodule : reading_duplicate_filter_table
`default_nettype wire
